// ===== rtl/rsnn_pkg.sv =====
// Shared types, constants and saturation helpers for the nodal normal unit.
`timescale 1ns / 1ps

package rsnn_pkg;

  localparam int NODE_CAPACITY_DEF = 1024;
  localparam int MAX_NODES_DEF     = 4;
  localparam logic [2:0] NPE_RESET = 3'd4;
  localparam logic [2:0] NPE_MIN   = 3'd3;

  // Widths of the corner cross products, their magnitudes and the divider remainder.
  localparam int CX_W  = 49;
  localparam int ABS_W = 48;
  localparam int MAG_W = 49;
  localparam int REM_W = 50;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_FETCH, S_CROSS, S_ABS, S_NORM, S_SQSUM,
    S_ROOT, S_DIV, S_MRD, S_MACC, S_RRD, S_RSQ, S_RROOT, S_RDIV, S_RDONE
  } state_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } ds_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat32(s);
  endfunction

endpackage

// ===== rtl/rsnn_mul.sv =====
// Shared signed 32 by 32 multiplier with a registered product.
`timescale 1ns / 1ps

module rsnn_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/rsnn_divsqrt.sv =====
// Shared radix-2 unit: Q8.24 saturating division or 64-bit floor square root.
`timescale 1ns / 1ps

module rsnn_divsqrt (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rsnn_pkg::ds_req_t                      req,
  input  logic signed [rsnn_pkg::CX_W-1:0]       num,
  input  logic        [rsnn_pkg::MAG_W-1:0]      den,
  input  logic        [63:0]                     rad,
  output rsnn_pkg::ds_rsp_t                      rsp
);

  logic                             busy;
  logic                             done;
  logic                             op_sqrt;
  logic [4:0]                       cnt;
  logic [rsnn_pkg::REM_W-1:0]       rem;
  logic [63:0]                      sh;
  logic [31:0]                      q;
  logic [rsnn_pkg::MAG_W-1:0]       den_r;
  logic                             neg;
  logic                             sat;
  logic [rsnn_pkg::CX_W-1:0]        mag;
  logic [rsnn_pkg::CX_W-1:0]        hi;
  logic [rsnn_pkg::REM_W:0]         cand;
  logic [rsnn_pkg::REM_W:0]         trial;
  logic [rsnn_pkg::REM_W:0]         diff;
  logic                             ge;

  always_comb begin
    mag   = num[rsnn_pkg::CX_W-1] ? rsnn_pkg::CX_W'(-num) : rsnn_pkg::CX_W'(num);
    hi    = mag >> 8;
    if (op_sqrt) begin
      cand  = {rem[rsnn_pkg::REM_W-2:0], sh[63:62]};
      trial = (rsnn_pkg::REM_W+1)'({q, 2'b01});
    end else begin
      cand  = {rem, sh[63]};
      trial = (rsnn_pkg::REM_W+1)'(den_r);
    end
    ge   = cand >= trial;
    diff = cand - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_sqrt <= req.is_sqrt;
      cnt     <= '0;
      q       <= '0;
      den_r   <= den;
      neg     <= num[rsnn_pkg::CX_W-1];
      if (req.is_sqrt) begin
        rem <= '0;
        sh  <= rad;
        sat <= 1'b0;
      end else begin
        // The integer part of the quotient is known to need 32 bits or fewer
        // unless the top of the shifted numerator already reaches the divisor.
        rem <= rsnn_pkg::REM_W'(hi);
        sh  <= {mag[7:0], 24'd0, 32'd0};
        sat <= rsnn_pkg::REM_W'(hi) >= rsnn_pkg::REM_W'(den);
      end
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      rem <= ge ? diff[rsnn_pkg::REM_W-1:0] : cand[rsnn_pkg::REM_W-1:0];
      q   <= {q[30:0], ge};
      sh  <= op_sqrt ? {sh[61:0], 2'b00} : {sh[62:0], 1'b0};
    end
  end

  always_comb begin
    rsp.done = done;
    if (op_sqrt) begin
      rsp.res = q;
    end else if (sat) begin
      rsp.res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg) begin
      rsp.res = (q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    end else begin
      rsp.res = q[31] ? 32'h7FFF_FFFF : q;
    end
  end

endmodule

// ===== rtl/reference_scaled_nodal_normal_unit.sv =====
// Top level: sequencer, vertex buffer, nodal accumulator store and output register.
// A load item writes its six coordinates to the vertex buffer; the closing vertex of an element
// then works each corner, mostly one root and six divides on the shared unit.
// A read does three squares, one root and three divides.
// Reset (synchronous, active high) and a clear item start a pass that zeroes the
// whole store one node per cycle, while no item is accepted.
// A result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module reference_scaled_nodal_normal_unit #(
  parameter int NODE_CAPACITY     = rsnn_pkg::NODE_CAPACITY_DEF,
  parameter int MAX_ELEMENT_NODES = rsnn_pkg::MAX_NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_id, pos_x, pos_y, pos_z, ref_x, ref_y, ref_z, zero fill
  input  logic [207:0] s_axis_tdata,
  // action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // read_node, normal_x, normal_y, normal_z, zero fill
  output logic [111:0] m_axis_tdata,
  // was_scaled
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_wr_data
);

  localparam int AW  = $clog2(NODE_CAPACITY);
  localparam int VBD = MAX_ELEMENT_NODES * 6;
  localparam int VAW = $clog2(VBD);
  localparam int SW  = $clog2(MAX_ELEMENT_NODES);

  rsnn_pkg::state_t state, state_next;

  logic [AW-1:0]              clr_cnt;
  logic [2:0]                 npe;
  logic [SW-1:0]              cnt;
  logic [9:0]                 in_node;
  logic signed [31:0]         in_crd [6];
  logic [9:0]                 vid [MAX_ELEMENT_NODES];

  logic signed [31:0]         vbuf [VBD];
  logic                       vb_we;
  logic [VAW-1:0]             vb_waddr;
  logic [VAW-1:0]             vb_raddr;
  logic signed [31:0]         vb_rdata;

  logic [191:0]               mem [NODE_CAPACITY];
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  logic [191:0]               mem_wdata;
  logic [191:0]               mem_rdata;

  logic [2:0]                 ld_idx;
  logic [SW-1:0]              ci;
  logic [SW-1:0]              nxt_i;
  logic [SW-1:0]              prv_i;
  logic [SW-1:0]              vtx;
  logic                       geo;
  logic [1:0]                 dd;
  logic [1:0]                 fs;
  logic [2:0]                 mc;
  logic [2:0]                 dj;
  logic                       issued;
  logic                       scaled;
  logic                       last_corner;
  logic                       node_ok;
  logic                       read_ok;
  logic                       adv_corner;

  logic signed [31:0]         here_v;
  logic signed [31:0]         e1 [3];
  logic signed [31:0]         e2 [3];
  logic signed [47:0]         ptmp;
  logic signed [47:0]         pshift;
  logic signed [rsnn_pkg::CX_W-1:0] cx [6];
  logic [rsnn_pkg::ABS_W-1:0] a_abs [3];
  logic [rsnn_pkg::ABS_W-1:0] abs_c [3];
  logic [rsnn_pkg::ABS_W-1:0] mn;
  logic [rsnn_pkg::ABS_W-1:0] s_val;
  logic [4:0]                 kk;
  logic [63:0]                sqsum;
  logic [rsnn_pkg::MAG_W-1:0] cmag;
  logic signed [31:0]         q [6];

  logic signed [31:0]         mul_a;
  logic signed [31:0]         mul_b;
  logic signed [63:0]         mul_p;
  rsnn_pkg::ds_req_t          ds_req;
  rsnn_pkg::ds_rsp_t          ds_rsp;
  logic signed [rsnn_pkg::CX_W-1:0] ds_num;

  logic [9:0]                 o_node;
  logic signed [31:0]         o_x;
  logic signed [31:0]         o_y;
  logic signed [31:0]         o_z;
  logic                       o_sc;
  logic                       m_valid;

  rsnn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rsnn_divsqrt u_ds (
    .clk (clk),
    .rst (rst),
    .req (ds_req),
    .num (ds_num),
    .den (cmag),
    .rad (sqsum),
    .rsp (ds_rsp)
  );

  // Memories: vertex buffer and accumulator store, registered reads.
  always_ff @(posedge clk) begin
    if (vb_we) begin
      vbuf[vb_waddr] <= in_crd[ld_idx];
    end
    vb_rdata <= vbuf[vb_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    last_corner = (3'(ci) == npe - 3'd1);
    nxt_i       = last_corner ? '0 : ci + SW'(1);
    prv_i       = (ci == '0) ? SW'(npe - 3'd1) : ci - SW'(1);
    unique case (fs)
      2'd0:    vtx = ci;
      2'd1:    vtx = nxt_i;
      default: vtx = prv_i;
    endcase
    vb_raddr = VAW'(32'(vtx) * 6 + 32'(geo) * 3 + 32'(dd));
    vb_waddr = VAW'(32'(cnt) * 6 + 32'(ld_idx));
    node_ok  = 32'(vid[ci]) < 32'(NODE_CAPACITY);
    read_ok  = 32'(in_node) < 32'(NODE_CAPACITY);
    pshift   = mul_p[63:16];
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = cx[3+i][rsnn_pkg::CX_W-1] ? rsnn_pkg::ABS_W'(-cx[3+i])
                                           : rsnn_pkg::ABS_W'(cx[3+i]);
    end
    s_val = (mc < 3'd3) ? (a_abs[mc[1:0]] >> kk) : '0;
  end

  always_comb begin
    state_next = state;
    vb_we      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = clr_cnt;
    mem_raddr  = AW'(vid[ci]);
    mem_wdata  = '0;
    mul_a      = '0;
    mul_b      = '0;
    ds_req     = '0;
    ds_num     = cx[dj];
    adv_corner = 1'b0;
    unique case (state)
      rsnn_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == AW'(NODE_CAPACITY - 1)) begin
          state_next = rsnn_pkg::S_IDLE;
        end
      end
      rsnn_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (s_axis_tuser)
            rsnn_pkg::ACT_CLEAR: state_next = rsnn_pkg::S_CLEAR;
            rsnn_pkg::ACT_LOAD:  state_next = rsnn_pkg::S_LOAD;
            rsnn_pkg::ACT_READ:  state_next = rsnn_pkg::S_RRD;
            default:             state_next = rsnn_pkg::S_IDLE;
          endcase
        end
      end
      rsnn_pkg::S_LOAD: begin
        vb_we = 1'b1;
        if (ld_idx == 3'd5) begin
          state_next = (3'(cnt) + 3'd1 >= npe) ? rsnn_pkg::S_FETCH : rsnn_pkg::S_IDLE;
        end
      end
      rsnn_pkg::S_FETCH: begin
        if (fs == 2'd3 && dd == 2'd2) begin
          state_next = rsnn_pkg::S_CROSS;
        end
      end
      rsnn_pkg::S_CROSS: begin
        case (mc)
          3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
          3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
          3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
          3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
          3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
          3'd5:    begin mul_a = e1[1]; mul_b = e2[0]; end
          default: begin mul_a = '0;    mul_b = '0;    end
        endcase
        if (mc == 3'd6) begin
          state_next = geo ? rsnn_pkg::S_ABS : rsnn_pkg::S_FETCH;
        end
      end
      rsnn_pkg::S_ABS: state_next = rsnn_pkg::S_NORM;
      rsnn_pkg::S_NORM: begin
        if (mn[rsnn_pkg::ABS_W-1:31] == '0) begin
          state_next = rsnn_pkg::S_SQSUM;
        end
      end
      rsnn_pkg::S_SQSUM: begin
        mul_a = 32'(s_val);
        mul_b = 32'(s_val);
        if (mc == 3'd3) begin
          state_next = rsnn_pkg::S_ROOT;
        end
      end
      rsnn_pkg::S_ROOT: begin
        ds_req.start   = !issued;
        ds_req.is_sqrt = 1'b1;
        if (ds_rsp.done) begin
          if (ds_rsp.res == '0 || !node_ok) begin
            adv_corner = 1'b1;
            state_next = last_corner ? rsnn_pkg::S_IDLE : rsnn_pkg::S_FETCH;
          end else begin
            state_next = rsnn_pkg::S_DIV;
          end
        end
      end
      rsnn_pkg::S_DIV: begin
        ds_req.start = !issued;
        if (ds_rsp.done && dj == 3'd5) begin
          state_next = rsnn_pkg::S_MRD;
        end
      end
      rsnn_pkg::S_MRD: begin
        mem_re     = 1'b1;
        state_next = rsnn_pkg::S_MACC;
      end
      rsnn_pkg::S_MACC: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(vid[ci]);
        for (int i = 0; i < 6; i++) begin
          mem_wdata[32*i +: 32] = rsnn_pkg::sat_add32(mem_rdata[32*i +: 32], q[i]);
        end
        adv_corner = 1'b1;
        state_next = last_corner ? rsnn_pkg::S_IDLE : rsnn_pkg::S_FETCH;
      end
      rsnn_pkg::S_RRD: begin
        mem_raddr = AW'(in_node);
        mem_re    = read_ok;
        state_next = read_ok ? rsnn_pkg::S_RSQ : rsnn_pkg::S_RDONE;
      end
      rsnn_pkg::S_RSQ: begin
        case (mc)
          3'd0:    begin mul_a = mem_rdata[127:96];  mul_b = mem_rdata[127:96];  end
          3'd1:    begin mul_a = mem_rdata[159:128]; mul_b = mem_rdata[159:128]; end
          3'd2:    begin mul_a = mem_rdata[191:160]; mul_b = mem_rdata[191:160]; end
          default: begin mul_a = '0;                 mul_b = '0;                 end
        endcase
        if (mc == 3'd3) begin
          state_next = rsnn_pkg::S_RROOT;
        end
      end
      rsnn_pkg::S_RROOT: begin
        ds_req.start   = !issued;
        ds_req.is_sqrt = 1'b1;
        if (ds_rsp.done) begin
          state_next = (ds_rsp.res == '0) ? rsnn_pkg::S_RDONE : rsnn_pkg::S_RDIV;
        end
      end
      rsnn_pkg::S_RDIV: begin
        ds_req.start = !issued;
        case (dj)
          3'd0:    ds_num = rsnn_pkg::CX_W'(signed'(mem_rdata[31:0]));
          3'd1:    ds_num = rsnn_pkg::CX_W'(signed'(mem_rdata[63:32]));
          default: ds_num = rsnn_pkg::CX_W'(signed'(mem_rdata[95:64]));
        endcase
        if (ds_rsp.done && dj == 3'd2) begin
          state_next = rsnn_pkg::S_RDONE;
        end
      end
      rsnn_pkg::S_RDONE: begin
        if (!m_valid || m_axis_tready) begin
          state_next = rsnn_pkg::S_IDLE;
        end
      end
      default: state_next = rsnn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsnn_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      npe     <= rsnn_pkg::NPE_RESET;
      cnt     <= '0;
      issued  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (state == rsnn_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end else if (state == rsnn_pkg::S_IDLE) begin
        clr_cnt <= '0;
      end
      if (state == rsnn_pkg::S_LOAD && ld_idx == 3'd5) begin
        cnt <= (3'(cnt) + 3'd1 >= npe) ? '0 : cnt + SW'(1);
      end
      if (cfg_wr_en) begin
        if (cfg_wr_data < rsnn_pkg::NPE_MIN) begin
          npe <= rsnn_pkg::NPE_MIN;
        end else if (cfg_wr_data > 3'(MAX_ELEMENT_NODES)) begin
          npe <= 3'(MAX_ELEMENT_NODES);
        end else begin
          npe <= cfg_wr_data;
        end
        cnt <= '0;
      end
      if (ds_req.start) begin
        issued <= 1'b1;
      end else if (ds_rsp.done) begin
        issued <= 1'b0;
      end
      if (state == rsnn_pkg::S_RDONE && (!m_valid || m_axis_tready)) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      rsnn_pkg::S_IDLE: begin
        in_node <= s_axis_tdata[9:0];
        for (int i = 0; i < 6; i++) begin
          in_crd[i] <= s_axis_tdata[10 + 32*i +: 32];
        end
        ld_idx <= '0;
      end
      rsnn_pkg::S_LOAD: begin
        vid[cnt] <= in_node;
        ld_idx   <= ld_idx + 3'd1;
        ci       <= '0;
        geo      <= 1'b0;
        dd       <= '0;
        fs       <= '0;
      end
      rsnn_pkg::S_FETCH: begin
        fs <= fs + 2'd1;
        case (fs)
          2'd1:    here_v <= vb_rdata;
          2'd2:    e1[dd] <= rsnn_pkg::sat32({vb_rdata[31], vb_rdata} - {here_v[31], here_v});
          default: begin
            if (fs == 2'd3) begin
              e2[dd] <= rsnn_pkg::sat32({vb_rdata[31], vb_rdata} - {here_v[31], here_v});
              dd     <= (dd == 2'd2) ? 2'd0 : dd + 2'd1;
              mc     <= '0;
            end
          end
        endcase
      end
      rsnn_pkg::S_CROSS: begin
        mc <= mc + 3'd1;
        if (mc != 3'd0) begin
          // Even products are held, odd ones close one cross component.
          if (!mc[0]) begin
            cx[3'(32'(geo) * 3 + 32'((mc - 3'd1) >> 1))] <=
              {ptmp[47], ptmp} - {pshift[47], pshift};
          end else begin
            ptmp <= pshift;
          end
        end
        if (mc == 3'd6) begin
          geo <= 1'b1;
        end
      end
      rsnn_pkg::S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          a_abs[i] <= abs_c[i];
        end
        if (abs_c[0] >= abs_c[1] && abs_c[0] >= abs_c[2]) begin
          mn <= abs_c[0];
        end else if (abs_c[1] >= abs_c[2]) begin
          mn <= abs_c[1];
        end else begin
          mn <= abs_c[2];
        end
        kk <= '0;
      end
      rsnn_pkg::S_NORM: begin
        if (mn[rsnn_pkg::ABS_W-1:31] != '0) begin
          mn <= mn >> 1;
          kk <= kk + 5'd1;
        end
        mc    <= '0;
        sqsum <= '0;
      end
      rsnn_pkg::S_SQSUM: begin
        mc <= mc + 3'd1;
        if (mc != 3'd0) begin
          sqsum <= sqsum + 64'(mul_p);
        end
      end
      rsnn_pkg::S_ROOT: begin
        dj <= '0;
        if (ds_rsp.done) begin
          cmag <= rsnn_pkg::MAG_W'(ds_rsp.res) << kk;
        end
        if (adv_corner) begin
          ci  <= nxt_i;
          geo <= 1'b0;
          dd  <= '0;
          fs  <= '0;
        end
      end
      rsnn_pkg::S_DIV: begin
        if (ds_rsp.done) begin
          q[dj] <= ds_rsp.res;
          dj    <= dj + 3'd1;
        end
      end
      rsnn_pkg::S_MRD: begin
        dj <= '0;
      end
      rsnn_pkg::S_MACC: begin
        ci  <= nxt_i;
        geo <= 1'b0;
        dd  <= '0;
        fs  <= '0;
      end
      rsnn_pkg::S_RRD: begin
        mc     <= '0;
        sqsum  <= '0;
        scaled <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          q[i] <= '0;
        end
      end
      rsnn_pkg::S_RSQ: begin
        mc <= mc + 3'd1;
        if (mc != 3'd0) begin
          sqsum <= sqsum + 64'(mul_p);
        end
      end
      rsnn_pkg::S_RROOT: begin
        dj <= '0;
        if (ds_rsp.done) begin
          cmag   <= rsnn_pkg::MAG_W'(ds_rsp.res);
          scaled <= (ds_rsp.res != '0);
          for (int i = 0; i < 3; i++) begin
            q[i] <= mem_rdata[32*i +: 32];
          end
        end
      end
      rsnn_pkg::S_RDIV: begin
        if (ds_rsp.done) begin
          q[dj] <= ds_rsp.res;
          dj    <= dj + 3'd1;
        end
      end
      rsnn_pkg::S_RDONE: begin
        if (!m_valid || m_axis_tready) begin
          o_node <= in_node;
          o_x    <= q[0];
          o_y    <= q[1];
          o_z    <= q[2];
          o_sc   <= scaled;
        end
      end
      default: begin
        ld_idx <= ld_idx;
      end
    endcase
  end

  assign s_axis_tready = (state == rsnn_pkg::S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'd0, o_z, o_y, o_x, o_node};
  assign m_axis_tuser  = o_sc;

  a_cnt_below_npe: assert property (@(posedge clk) disable iff (rst)
    (3'(cnt) < npe))
    else $error("vertex count reached element size");

  a_ds_done_owned: assert property (@(posedge clk) disable iff (rst)
    ds_rsp.done |-> (state == rsnn_pkg::S_ROOT || state == rsnn_pkg::S_DIV ||
                     state == rsnn_pkg::S_RROOT || state == rsnn_pkg::S_RDIV))
    else $error("shared unit finished outside a root or divide step");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == rsnn_pkg::S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_load_after_rdone: assert property (@(posedge clk) disable iff (rst)
    (state == rsnn_pkg::S_RDONE && state_next == rsnn_pkg::S_IDLE) |=> m_valid)
    else $error("read result lost on leaving the result state");

endmodule

// ===== bench/reference_scaled_nodal_normal_unit_test.sv =====
// Self-checking testbench for the reference-scaled nodal normal unit.
`timescale 1ns / 1ps

module reference_scaled_nodal_normal_unit_test;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int NODES = 1024;
  localparam int SETTLE_CYCLES = 1500;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic [9:0]         node;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic               scaled;
  } normal_rec_t;

  // Tracks the accumulator store and holds the normals still to come back.
  class normal_scoreboard;
    int cur_sum[3][NODES];
    int ref_sum[3][NODES];
    int vbuf[4][6];
    int unsigned vids[4];
    int unsigned vcount;
    int unsigned npe;
    normal_rec_t pending_normals[$];
    int errors;
    int checked;

    function new();
      wipe();
      vcount = 0;
      npe = 4;
      errors = 0;
      checked = 0;
    endfunction

    function void wipe();
      foreach (cur_sum[a, b]) begin
        cur_sum[a][b] = 0;
        ref_sum[a][b] = 0;
      end
    endfunction

    function void configure(logic [2:0] v);
      npe = (v < 3) ? 3 : (v > 4) ? 4 : v;
      vcount = 0;
    endfunction

    function longint sat(longint v);
      return (v > S32_MAX) ? S32_MAX : (v < S32_MIN) ? S32_MIN : v;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    // Signed quotient into Q8.24, truncated towards zero and saturated.
    function longint quot_q24(longint num, longint unsigned den);
      longint unsigned mag, q, r;
      bit neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q = mag / den;
      r = mag % den;
      if (q >= (64'd1 << 31)) begin
        q = 64'd1 << 55;
      end else begin
        for (int k = 0; k < 24; k++) begin
          q <<= 1;
          r <<= 1;
          if (r >= den) begin
            r -= den;
            q |= 1;
          end
        end
      end
      if (neg) return (q > (64'd1 << 31)) ? S32_MIN : -longint'(q);
      return (q > S32_MAX) ? S32_MAX : longint'(q);
    endfunction

    function void corner(int unsigned i, int unsigned n, int geo, output longint c[3]);
      int unsigned prv, nxt;
      longint e1[3], e2[3], here;
      prv = (i + n - 1) % n;
      nxt = (i + 1) % n;
      for (int d = 0; d < 3; d++) begin
        here = vbuf[i][geo + d];
        e1[d] = sat(longint'(vbuf[nxt][geo + d]) - here);
        e2[d] = sat(longint'(vbuf[prv][geo + d]) - here);
      end
      c[0] = ((e1[1] * e2[2]) >>> 16) - ((e1[2] * e2[1]) >>> 16);
      c[1] = ((e1[2] * e2[0]) >>> 16) - ((e1[0] * e2[2]) >>> 16);
      c[2] = ((e1[0] * e2[1]) >>> 16) - ((e1[1] * e2[0]) >>> 16);
    endfunction

    // Components are scaled down together until each fits in 31 bits.
    function longint unsigned magnitude(longint c[3]);
      longint unsigned a[3], m, s, sum;
      int k;
      m = 0;
      sum = 0;
      k = 0;
      for (int d = 0; d < 3; d++) begin
        a[d] = (c[d] < 0) ? -c[d] : c[d];
        if (a[d] > m) m = a[d];
      end
      while ((m >> k) >= (64'd1 << 31)) k++;
      for (int d = 0; d < 3; d++) begin
        s = a[d] >> k;
        sum += s * s;
      end
      return root(sum) << k;
    endfunction

    function void close_element(int unsigned n);
      longint cc[3], cr[3];
      longint unsigned mag;
      int unsigned node;
      for (int unsigned i = 0; i < n; i++) begin
        node = vids[i];
        corner(i, n, 0, cc);
        corner(i, n, 3, cr);
        mag = magnitude(cr);
        if (mag != 0 && node < NODES) begin
          for (int d = 0; d < 3; d++) begin
            cur_sum[d][node] = sat(longint'(cur_sum[d][node]) + quot_q24(cc[d], mag));
            ref_sum[d][node] = sat(longint'(ref_sum[d][node]) + quot_q24(cr[d], mag));
          end
        end
      end
    endfunction

    function void note_input(logic [1:0] act, logic [9:0] node, int c[6]);
      int unsigned slot;
      longint unsigned sq, mag;
      longint v[3];
      normal_rec_t rec;
      case (act)
        rsnn_pkg::ACT_CLEAR: wipe();
        rsnn_pkg::ACT_LOAD: begin
          slot = (vcount >= 4) ? 0 : vcount;
          for (int d = 0; d < 6; d++) vbuf[slot][d] = c[d];
          vids[slot] = node;
          vcount = slot + 1;
          if (vcount >= npe) begin
            close_element(npe);
            vcount = 0;
          end
        end
        rsnn_pkg::ACT_READ: begin
          sq = 0;
          for (int d = 0; d < 3; d++) begin
            v[d] = ref_sum[d][node];
            sq += longint'(v[d] * v[d]);
          end
          mag = root(sq);
          for (int d = 0; d < 3; d++) begin
            v[d] = cur_sum[d][node];
            if (mag != 0) v[d] = quot_q24(v[d], mag);
          end
          rec.node = node;
          rec.nx = v[0];
          rec.ny = v[1];
          rec.nz = v[2];
          rec.scaled = (mag != 0);
          pending_normals.push_back(rec);
        end
        default: ;
      endcase
    endfunction

    function void check(logic [9:0] node, logic [31:0] nx, logic [31:0] ny,
                        logic [31:0] nz, logic scaled);
      normal_rec_t e;
      if (pending_normals.size() == 0) begin
        $error("unexpected normal for node %0d", node);
        errors++;
        return;
      end
      e = pending_normals.pop_front();
      checked++;
      if (node !== e.node) begin
        $error("read_node: expected %0d, got %0d", e.node, node);
        errors++;
      end
      if (nx !== e.nx) begin
        $error("normal_x: expected %h, got %h", e.nx, nx);
        errors++;
      end
      if (ny !== e.ny) begin
        $error("normal_y: expected %h, got %h", e.ny, ny);
        errors++;
      end
      if (nz !== e.nz) begin
        $error("normal_z: expected %h, got %h", e.nz, nz);
        errors++;
      end
      if (scaled !== e.scaled) begin
        $error("was_scaled: expected %0d, got %0d", e.scaled, scaled);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = rsnn_pkg::ACT_CLEAR;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;

  normal_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_cycles = 0;
  int items_sent = 0;
  int elements_sent = 0;

  reference_scaled_nodal_normal_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: checks each transfer and stalls in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check(m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tdata[73:42],
                 m_axis_tdata[105:74], m_axis_tuser[0]);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [9:0] node, int c[6]);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {6'b0, c[5], c[4], c[3], c[2], c[1], c[0], node};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(act, node, c);
    items_sent++;
  endtask

  task automatic send_simple(logic [1:0] act, logic [9:0] node);
    int c[6];
    foreach (c[d]) c[d] = $urandom;
    send_item(act, node, c);
  endtask

  // Lets every outstanding normal return, then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.configure(v);
  endtask

  // One element around a random centre; now and then a corner is made degenerate.
  task automatic send_element(int unsigned n, int unsigned pool);
    int c[6];
    int ctr[3];
    int refv[4][3];
    bit degenerate, noisy;
    foreach (ctr[d]) ctr[d] = $urandom_range(0, 1 << 21) - (1 << 20);
    degenerate = ($urandom_range(0, 9) == 0);
    for (int v = 0; v < n; v++) begin
      for (int d = 0; d < 3; d++) refv[v][d] = ctr[d] + $urandom_range(0, 1 << 19) - (1 << 18);
    end
    if (degenerate) refv[0] = refv[1];
    for (int v = 0; v < n; v++) begin
      noisy = ($urandom_range(0, 19) == 0);
      for (int d = 0; d < 3; d++) begin
        c[3 + d] = noisy ? $urandom : refv[v][d];
        c[d] = noisy ? $urandom : refv[v][d] + $urandom_range(0, 1 << 15) - (1 << 14);
      end
      send_item(rsnn_pkg::ACT_LOAD,
                ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(0, pool)), c);
    end
    elements_sent++;
  endtask

  initial begin
    int c[6];
    logic [2:0] phase_cfg[4] = '{3'd3, 3'd0, 3'd4, 3'd3};
    int per_phase;
    int unsigned pick, n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_cfg(3'd7);

    // Directed part: extremes, saturation, degenerate geometry, every action.
    send_simple(rsnn_pkg::ACT_READ, 10'd0);
    c = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0};
    send_item(rsnn_pkg::ACT_LOAD, 10'd0, c);
    c = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0};
    send_item(rsnn_pkg::ACT_LOAD, 10'd1023, c);
    c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000};
    send_item(rsnn_pkg::ACT_LOAD, 10'd5, c);
    c = '{0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF};
    send_item(rsnn_pkg::ACT_LOAD, 10'd6, c);
    send_simple(rsnn_pkg::ACT_READ, 10'd0);
    send_simple(rsnn_pkg::ACT_READ, 10'd1023);
    c = '{32'h00010000, 32'h00020000, 0, 32'h00010000, 32'h00020000, 0};
    for (int v = 0; v < 4; v++) send_item(rsnn_pkg::ACT_LOAD, 10'd2, c);
    send_simple(rsnn_pkg::ACT_READ, 10'd2);
    send_element(4, 3);
    send_simple(rsnn_pkg::ACT_READ, 10'd1);
    send_simple(ACT_UNUSED, 10'd1023);
    send_element(4, 3);
    send_element(4, 3);
    send_simple(rsnn_pkg::ACT_LOAD, 10'd9);
    send_simple(rsnn_pkg::ACT_CLEAR, 10'd0);
    send_simple(rsnn_pkg::ACT_READ, 10'd3);
    send_element(4, 3);
    drain();

    // Random phases, each after its own write of the element size.
    per_phase = (1350 - items_sent) / 4;
    for (int p = 0; p < 4; p++) begin
      write_cfg(phase_cfg[p]);
      n = sb.npe;
      while (items_sent < 25 + per_phase * (p + 1)) begin
        if (p == 3 && items_sent > 1200) quiet = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 55) send_element(n, 15);
        else if (pick < 85) send_simple(rsnn_pkg::ACT_READ, 10'($urandom_range(0, 15)));
        else if (pick < 89) send_simple(rsnn_pkg::ACT_READ, 10'($urandom_range(0, 1023)));
        else if (pick < 91) send_simple(rsnn_pkg::ACT_CLEAR, 10'($urandom_range(0, 1023)));
        else if (pick < 96) send_simple(rsnn_pkg::ACT_LOAD, 10'($urandom_range(0, 1023)));
        else send_simple(ACT_UNUSED, 10'($urandom_range(0, 1023)));
      end
      if (p == 1) begin
        // Long stall on the result side while reads keep coming.
        hold_cycles = 3000;
        for (int r = 0; r < 8; r++) begin
          send_simple(rsnn_pkg::ACT_READ, 10'($urandom_range(0, 15)));
        end
      end
      // Leave a partial element so the next register write has to drop it.
      if (p < 3) send_simple(rsnn_pkg::ACT_LOAD, 10'($urandom_range(0, 15)));
      drain();
    end

    s_axis_tvalid <= 1'b0;
    if (sb.pending_normals.size() != 0) begin
      $error("%0d normals never arrived", sb.pending_normals.size());
      sb.errors++;
    end
    $display("Sent %0d items (%0d elements); %0d normals checked across sizes 3 and 4,",
             items_sent, elements_sent, sb.checked);
    $display("with clears, degenerate corners, saturating coordinates and output stalls.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
